/* hw/rtl/ntae_pkg.sv */
// Shared types and constants for the neighbor table aging/evict unit.
// Holds command codes, entry and sweep token structs, and the port payloads.
// No dependencies.
`default_nettype none

package ntae_pkg;

    // Table geometry
    localparam int TABLE_DEPTH   = 8;
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int CMD_W         = 3;
    localparam int ENTRY_COUNT_W = 4;

    localparam logic [BYTE_W-1:0] ACT_MAX = 8'd255;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_AGE     = 3'd4;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] rtt;
        logic [BYTE_W-1:0] act;
        logic [BYTE_W-1:0] rel;
        logic [BYTE_W-1:0] spare;
    } entry_t;

    // Token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic              active;
        logic [CMD_W-1:0]  op;
        logic              pass2;    // second walk of a full-table insert
        entry_t            item;     // new entry carried by an insert
        logic [IDX_W-1:0]  idx;      // slot the token is entering
        logic [CNT_W-1:0]  count;    // valid entries when the command began
        logic              found;
        logic              shift;    // delete: close the gap from here on
        logic [BYTE_W-1:0] min_act;
        logic [IDX_W-1:0]  victim;
        logic [ADDR_W-1:0] ev_addr;
    } sweep_t;

    // Command transaction payload
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] neighbor_addr;
        logic [BYTE_W-1:0] round_trip;
        logic [BYTE_W-1:0] activity_in;
        logic [BYTE_W-1:0] reliability_in;
        logic [BYTE_W-1:0] spare_in;
    } request_t;

    // Result transaction payload
    typedef struct packed {
        logic                     found;
        logic                     evicted;
        logic [ADDR_W-1:0]        evicted_addr;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/neighbor_table_aging_evict_unit.sv */
// Neighbor table with aging and lowest-activity eviction, built as a chain of slot cells.
// done pulses after the launched token has walked the whole chain; an insert into a full
// table walks the chain twice. The token walks one cell a cycle; busy is low in the done
// cycle, so a new command may start then; none is taken while busy. Reset clears the valid
// count and control; entry contents are undefined until written. The receiver cannot stall.
`default_nettype none

module neighbor_table_aging_evict_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ntae_pkg::request_t  request,
    output logic                     busy,
    output logic                     done,
    output ntae_pkg::result_t        result
);

    ntae_pkg::sweep_t tok   [0:ntae_pkg::TABLE_DEPTH];
    ntae_pkg::entry_t slots [0:ntae_pkg::TABLE_DEPTH-1];

    // Sequencer
    ntae_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .ret     (tok[ntae_pkg::TABLE_DEPTH]),
        .launch  (tok[0]),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Chain of slot cells; each can pull the entry of the slot above it
    for (genvar i = 0; i < ntae_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        ntae_pkg::entry_t above;

        if (i < ntae_pkg::TABLE_DEPTH - 1)
        begin : g_mid
            assign above = slots[i+1];
        end
        else
        begin : g_last
            assign above = slots[i];
        end

        ntae_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (tok[i]),
            .next_entry (above),
            .tok_out    (tok[i+1]),
            .entry      (slots[i])
        );
    end

endmodule

`default_nettype wire

/* hw/rtl/ntae_cell.sv */
// One slot of the neighbor table: holds an entry and passes the sweep token on.
// Depends on ntae_pkg.
`default_nettype none

module ntae_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ntae_pkg::sweep_t  tok_in,
    input  wire ntae_pkg::entry_t  next_entry,
    output ntae_pkg::sweep_t       tok_out,
    output ntae_pkg::entry_t       entry
);

    ntae_pkg::entry_t entry_reg;
    ntae_pkg::entry_t entry_next;
    ntae_pkg::sweep_t tok_reg;
    ntae_pkg::sweep_t tok_next;
    logic             slot_valid;
    logic             hit;

    // Act on the token as it passes this slot
    always_comb
    begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        tok_next.idx = tok_in.idx + ntae_pkg::IDX_W'(1);
        slot_valid = ntae_pkg::CNT_W'(tok_in.idx) < tok_in.count;
        hit        = slot_valid && (entry_reg.addr == tok_in.item.addr);

        if (tok_in.active)
        begin
            case (tok_in.op)
                ntae_pkg::CMD_INSERT:
                begin
                    if (tok_in.pass2)
                    begin
                        // overwrite the chosen victim, remember its address
                        if (tok_in.idx == tok_in.victim)
                        begin
                            entry_next       = tok_in.item;
                            tok_next.ev_addr = entry_reg.addr;
                        end
                    end
                    else if (tok_in.count < ntae_pkg::CNT_W'(ntae_pkg::TABLE_DEPTH))
                    begin
                        // append at the first free slot
                        if (ntae_pkg::CNT_W'(tok_in.idx) == tok_in.count)
                            entry_next = tok_in.item;
                    end
                    else
                    begin
                        // full table: track first slot with lowest activity
                        if ((tok_in.idx == '0) || (entry_reg.act < tok_in.min_act))
                        begin
                            tok_next.min_act = entry_reg.act;
                            tok_next.victim  = tok_in.idx;
                        end
                    end
                end
                ntae_pkg::CMD_DELETE:
                begin
                    // remove the first match, pull later entries down
                    if (slot_valid && (tok_in.shift || hit))
                    begin
                        entry_next     = next_entry;
                        tok_next.shift = 1'b1;
                        tok_next.found = 1'b1;
                    end
                end
                ntae_pkg::CMD_LOOKUP:
                begin
                    if (hit)
                        tok_next.found = 1'b1;
                end
                ntae_pkg::CMD_REFRESH:
                begin
                    if (hit)
                    begin
                        entry_next.act = ntae_pkg::ACT_MAX;
                        tok_next.found = 1'b1;
                    end
                end
                ntae_pkg::CMD_AGE:
                begin
                    // saturate at zero
                    if (slot_valid && (entry_reg.act != '0))
                        entry_next.act = entry_reg.act - ntae_pkg::BYTE_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

`default_nettype wire

/* hw/rtl/ntae_ctrl.sv */
// Command sequencer: launches sweep tokens into the cell chain, keeps the
// valid count and forms the result transaction. Depends on ntae_pkg.
`default_nettype none

module ntae_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ntae_pkg::request_t  request,
    input  wire ntae_pkg::sweep_t    ret,
    output ntae_pkg::sweep_t         launch,
    output logic                     busy,
    output logic                     done,
    output ntae_pkg::result_t        result
);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    ntae_pkg::sweep_t            launch_reg;
    ntae_pkg::sweep_t            launch_next;
    logic [ntae_pkg::CNT_W-1:0]  count_reg;
    logic [ntae_pkg::CNT_W-1:0]  count_next;
    logic                        done_reg;
    logic                        done_next;
    ntae_pkg::result_t           result_reg;
    ntae_pkg::result_t           result_next;
    logic                        table_full;

    assign table_full = ret.count == ntae_pkg::CNT_W'(ntae_pkg::TABLE_DEPTH);

    // Sequence one command: start, sweep (twice for an eviction), report
    always_comb
    begin
        state_next  = state_reg;
        launch_next = launch_reg;
        launch_next.active = 1'b0;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    launch_next            = '0;
                    launch_next.active     = 1'b1;
                    launch_next.op         = request.command;
                    launch_next.item.addr  = request.neighbor_addr;
                    launch_next.item.rtt   = request.round_trip;
                    launch_next.item.act   = request.activity_in;
                    launch_next.item.rel   = request.reliability_in;
                    launch_next.item.spare = request.spare_in;
                    launch_next.count      = count_reg;
                    state_next             = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (ret.active)
                begin
                    if ((ret.op == ntae_pkg::CMD_INSERT) && !ret.pass2 && table_full)
                    begin
                        // victim known: walk again to overwrite it
                        launch_next       = ret;
                        launch_next.pass2 = 1'b1;
                        launch_next.idx   = '0;
                    end
                    else
                    begin
                        if ((ret.op == ntae_pkg::CMD_INSERT) && !ret.pass2)
                            count_next = ret.count + ntae_pkg::CNT_W'(1);
                        else if ((ret.op == ntae_pkg::CMD_DELETE) && ret.found)
                            count_next = ret.count - ntae_pkg::CNT_W'(1);
                        else
                            count_next = ret.count;

                        result_next.found        = ret.found;
                        result_next.evicted      = ret.pass2;
                        result_next.evicted_addr = ret.pass2 ? ret.ev_addr : '0;
                        result_next.entry_count  = ntae_pkg::ENTRY_COUNT_W'(count_next);
                        done_next                = 1'b1;
                        state_next               = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign launch = launch_reg;
    assign busy   = (state_reg == ST_SWEEP);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* tb/neighbor_table_aging_evict_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for neighbor_table_aging_evict_unit.
// Depends on ntae_pkg (ports, command codes) and the unit itself;
// an in-bench table model predicts every result.

module neighbor_table_aging_evict_unit_tb;
    import ntae_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 6;
    localparam int MAX_GAP      = 2 * TABLE_DEPTH + 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1630;
    localparam int POOL_SIZE    = 12;
    localparam int PRINT_LIMIT  = 40;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // Shadow copy of the neighbor table
    entry_t nbr_table [TABLE_DEPTH];
    int     nbr_count;

    result_t           pending_results [$];
    int                mismatch_count;
    int                cycle_count;
    logic              gaps_enabled;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    neighbor_table_aging_evict_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Generate the 2 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Apply one command to the shadow table and return what the unit should report
    function automatic result_t table_apply(input request_t req);
        result_t res;
        entry_t  fresh;
        int      victim;
        int      hit;
        res          = '0;
        fresh.addr   = req.neighbor_addr;
        fresh.rtt    = req.round_trip;
        fresh.act    = req.activity_in;
        fresh.rel    = req.reliability_in;
        fresh.spare  = req.spare_in;
        victim       = 0;
        hit          = -1;
        case (req.command)
            CMD_INSERT:
            begin
                if (nbr_count < TABLE_DEPTH)
                begin
                    nbr_table[nbr_count] = fresh;
                    nbr_count++;
                end
                else
                begin
                    // lowest activity wins, ties go to the lowest slot
                    for (int i = 1; i < nbr_count; i++)
                        if (nbr_table[i].act < nbr_table[victim].act)
                            victim = i;
                    res.evicted      = 1'b1;
                    res.evicted_addr = nbr_table[victim].addr;
                    nbr_table[victim] = fresh;
                end
            end
            CMD_DELETE:
            begin
                for (int i = nbr_count - 1; i >= 0; i--)
                    if (nbr_table[i].addr == req.neighbor_addr)
                        hit = i;
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    for (int j = hit; j + 1 < nbr_count; j++)
                        nbr_table[j] = nbr_table[j + 1];
                    nbr_count--;
                end
            end
            CMD_LOOKUP:
            begin
                for (int i = 0; i < nbr_count; i++)
                    if (nbr_table[i].addr == req.neighbor_addr)
                        res.found = 1'b1;
            end
            CMD_REFRESH:
            begin
                for (int i = 0; i < nbr_count; i++)
                    if (nbr_table[i].addr == req.neighbor_addr)
                    begin
                        nbr_table[i].act = ACT_MAX;
                        res.found        = 1'b1;
                    end
            end
            CMD_AGE:
            begin
                for (int i = 0; i < nbr_count; i++)
                    if (nbr_table[i].act != '0)
                        nbr_table[i].act = nbr_table[i].act - 1'b1;
            end
            default:
            begin
                // unknown codes leave the table alone
            end
        endcase
        res.entry_count = ENTRY_COUNT_W'(nbr_count);
        return res;
    endfunction

    function automatic request_t make_request(input logic [CMD_W-1:0] cmd,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [BYTE_W-1:0] act,
                                              input logic [BYTE_W-1:0] rtt,
                                              input logic [BYTE_W-1:0] rel,
                                              input logic [BYTE_W-1:0] spare);
        request_t req;
        req.command        = cmd;
        req.neighbor_addr  = addr;
        req.round_trip     = rtt;
        req.activity_in    = act;
        req.reliability_in = rel;
        req.spare_in       = spare;
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Idle at random, then hold start until the unit takes the transaction
    task automatic send_command(input request_t req);
        logic [63:0] noise;
        int          gap;
        gap = 0;
        if (gaps_enabled && $urandom_range(99) < 14)
            gap = $urandom_range(MAX_GAP, 1);
        repeat (gap)
        begin
            @(negedge clk);
            noise   = {$urandom, $urandom};
            start   <= 1'b0;
            request <= noise[$bits(request_t)-1:0];
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(table_apply(req));
    endtask

    // Compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(result), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found)
                    report_mismatch("found", 32'(result.found), 32'(want.found));
                if (result.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(result.evicted), 32'(want.evicted));
                if (result.evicted_addr !== want.evicted_addr)
                    report_mismatch("evicted_addr", 32'(result.evicted_addr),
                                    32'(want.evicted_addr));
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(result.entry_count),
                                    32'(want.entry_count));
            end
        end
    end

    // Commands on an empty table
    task automatic test_empty_table();
        send_command(make_request(CMD_LOOKUP, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_DELETE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_request(CMD_REFRESH, 16'h8000, 8'h12, 8'h34, 8'h56, 8'h78));
        send_command(make_request(CMD_AGE, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Fill the table with extremes and a duplicate, then evict on tied activity
    task automatic test_fill_and_evict();
        send_command(make_request(CMD_INSERT, 16'h0000, 8'd200, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_INSERT, 16'hFFFF, 8'd255, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_request(CMD_INSERT, 16'h1234, 8'd7, 8'h11, 8'h22, 8'h33));
        send_command(make_request(CMD_INSERT, 16'h1234, 8'd3, 8'h44, 8'h55, 8'h66));
        send_command(make_request(CMD_INSERT, 16'h5555, 8'd3, 8'h55, 8'h55, 8'h55));
        send_command(make_request(CMD_INSERT, 16'hAAAA, 8'd0, 8'hAA, 8'hAA, 8'hAA));
        send_command(make_request(CMD_INSERT, 16'h00FF, 8'd0, 8'h0F, 8'hF0, 8'h3C));
        send_command(make_request(CMD_INSERT, 16'hFF00, 8'd1, 8'hC3, 8'h5A, 8'hA5));
        send_command(make_request(CMD_INSERT, 16'h4321, 8'd100, 8'h01, 8'h02, 8'h03));
        send_command(make_request(CMD_INSERT, 16'h9999, 8'd50, 8'h04, 8'h05, 8'h06));
    endtask

    // Refresh duplicates, age down to zero and past it, then evict the saturated entry
    task automatic test_refresh_and_age();
        send_command(make_request(CMD_REFRESH, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_AGE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_AGE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_request(CMD_LOOKUP, 16'h9999, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_INSERT, 16'h7777, 8'd9, 8'h07, 8'h07, 8'h07));
    endtask

    // Delete the first of two duplicates, miss, and delete slot zero
    task automatic test_delete_shift();
        send_command(make_request(CMD_DELETE, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_DELETE, 16'hBEEF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_command(make_request(CMD_DELETE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_unknown_commands();
        for (int c = CMD_AGE + 1; c < (1 << CMD_W); c++)
            send_command(make_request(CMD_W'(c), 16'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom)));
    endtask

    // Random command mix over a small address pool, in fill, drain and mixed phases
    task automatic test_random_traffic(input int count);
        request_t req;
        int       insert_weight;
        int       roll;
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'hFFFF;
        for (int p = 2; p < POOL_SIZE; p++)
            addr_pool[p] = 16'($urandom);
        insert_weight = 35;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_weight = 60;
                    1:       insert_weight = 15;
                    default: insert_weight = 35;
                endcase
            end
            // hold a long run with no idle cycles
            gaps_enabled = !(n >= 600 && n < 900);
            req.round_trip     = 8'($urandom);
            req.reliability_in = 8'($urandom);
            req.spare_in       = 8'($urandom);
            case ($urandom_range(3))
                0:       req.activity_in = 8'($urandom_range(3));
                1:       req.activity_in = ACT_MAX;
                default: req.activity_in = 8'($urandom);
            endcase
            if ($urandom_range(9) < 7)
                req.neighbor_addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else
                req.neighbor_addr = 16'($urandom);
            if ($urandom_range(99) < insert_weight)
                req.command = CMD_INSERT;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                    req.command = CMD_DELETE;
                else if (roll < 50)
                    req.command = CMD_LOOKUP;
                else if (roll < 70)
                    req.command = CMD_REFRESH;
                else if (roll < 94)
                    req.command = CMD_AGE;
                else
                    req.command = CMD_W'($urandom_range((1 << CMD_W) - 1, CMD_AGE + 1));
            end
            send_command(req);
        end
        gaps_enabled = 1'b1;
    endtask

    // Stop a hung run
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main_sequence
        nbr_count      = 0;
        mismatch_count = 0;
        gaps_enabled   = 1'b1;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_and_evict();
        test_refresh_and_age();
        test_delete_shift();
        test_unknown_commands();
        test_random_traffic(RANDOM_ITEMS);

        // Drop start and drain outstanding results
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ntae_pkg.sv
hw/rtl/ntae_cell.sv
hw/rtl/ntae_ctrl.sv
hw/rtl/neighbor_table_aging_evict_unit.sv
tb/neighbor_table_aging_evict_unit_tb.sv
